// ===== sv/rob_pkg.sv =====
// Shared types and constants for the in-order-retire reorder buffer.
// Used by rob_front, rob_back and reorder_buffer_inorder_retire; no dependencies.
package rob_pkg;

  localparam int TagW     = 16;
  localparam int CountW   = 6;
  localparam int CapW     = 6;
  localparam int RwW      = 4;
  localparam int ResW     = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  localparam logic [CapW-1:0] CapReset = 6'd32;
  localparam logic [RwW-1:0]  RwReset  = 4'd8;

  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_RESP  = 2'd1,
    OP_STEP  = 2'd2
  } opcode_e;

  typedef enum logic [ResW-1:0] {
    RES_ALLOC   = 3'd0,
    RES_FULL    = 3'd1,
    RES_RESP    = 3'd2,
    RES_RETIRED = 3'd3,
    RES_NONE    = 3'd4
  } result_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY     = 1'b0,
    CFG_RETIRE_WIDTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_RESP,
    CMD_STEP
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RESP,
    BK_RET
  } back_state_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [TagW-1:0] msg_tag;
    logic [1:0]      inst_kind;
  } in_item_t;

  typedef struct packed {
    logic [ResW-1:0]   result_kind;
    logic [TagW-1:0]   retired_tag;
    logic [CountW-1:0] entry_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    cmd_e            op;
    logic [TagW-1:0] tag;
    logic            rdy;
  } cmd_t;

  typedef struct packed {
    logic [CapW-1:0] capacity;
    logic [RwW-1:0]  retire_width;
  } cfg_t;

endpackage

// ===== sv/rob_front.sv =====
// Front end: accepts input items, decodes them into commands and holds them
// in a two-entry queue for the back end. Depends on rob_pkg.
module rob_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rob_pkg::in_item_t in_item_i,
  output logic             cmd_valid_o,
  output rob_pkg::cmd_t    cmd_o,
  input  logic             cmd_pop_i
);
  import rob_pkg::*;

  cmd_t       q_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       keep, push, pop;

  always_comb begin
    keep     = 1'b1;
    cls.op   = CMD_ALLOC;
    cls.tag  = in_item_i.msg_tag;
    cls.rdy  = (in_item_i.inst_kind == KIND_WRITE) || (in_item_i.inst_kind == KIND_COMPUTE);
    unique case (in_item_i.opcode)
      OP_ALLOC: cls.op = CMD_ALLOC;
      OP_RESP:  cls.op = CMD_RESP;
      OP_STEP:  cls.op = CMD_STEP;
      default:  keep = 1'b0; // unused opcode: dropped
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    priority if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cls;
    end
  end

endmodule

// ===== sv/rob_back.sv =====
// Back end: circular tag memory, ready marks, pointers and the sequencer that
// allocates, scans for responses and retires in order. Depends on rob_pkg.
module rob_back #(
  parameter int DEPTH      = 32,
  parameter int MAX_RETIRE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rob_pkg::cfg_t              cfg_i,
  input  logic                       cmd_valid_i,
  input  rob_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rob_pkg::out_item_t         out_item_o,
  output logic [$clog2(DEPTH+1)-1:0] occ_o
);
  import rob_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int OccW = $clog2(DEPTH + 1);
  localparam int CntW = $clog2(MAX_RETIRE + 1);
  localparam int WW   = (CntW > RwW) ? CntW : RwW;
  localparam int CmpW = (OccW > CapW) ? OccW : CapW;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    return (i == IdxW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  back_state_e       state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d, scan_q, scan_d;
  logic [OccW-1:0]   occ_q, occ_d, left_q, left_d;
  logic [DEPTH-1:0]  rdy_q, rdy_d;
  logic [CntW-1:0]   n_q, n_d, n_inc;
  logic [TagW-1:0]   tag_q, tag_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [TagW-1:0]   mem_q [DEPTH];
  logic [TagW-1:0]   rdata_q;
  logic [IdxW-1:0]   raddr;
  logic              we;

  logic              out_free, cap_full, last_ret;
  logic [IdxW-1:0]   head_nx;
  logic [WW-1:0]     rw_ext, w_eff;

  assign out_free = !out_valid_q || out_ready_i;
  assign head_nx  = nxt(head_q);
  assign cap_full = (CmpW'(occ_q) >= CmpW'(cfg_i.capacity)) || (occ_q == OccW'(DEPTH));
  assign rw_ext   = WW'(cfg_i.retire_width);
  assign w_eff    = (rw_ext > WW'(MAX_RETIRE)) ? WW'(MAX_RETIRE) : rw_ext;
  assign n_inc    = n_q + 1'b1;
  assign last_ret = (WW'(n_inc) == w_eff) || (occ_q == OccW'(1)) || !rdy_q[head_nx];

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    scan_d    = scan_q;
    occ_d     = occ_q;
    left_d    = left_q;
    rdy_d     = rdy_q;
    n_d       = n_q;
    tag_d     = tag_q;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    raddr     = head_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            CMD_ALLOC: begin
              out_valid_d       = 1'b1;
              out_d.retired_tag = '0;
              out_d.last        = 1'b1;
              if (cap_full) begin
                out_d.result_kind = RES_FULL;
                out_d.entry_count = CountW'(occ_q);
              end else begin
                we            = 1'b1;
                rdy_d[tail_q] = cmd_i.rdy;
                tail_d        = nxt(tail_q);
                occ_d         = occ_q + 1'b1;
                out_d.result_kind = RES_ALLOC;
                out_d.entry_count = CountW'(occ_d);
              end
            end
            CMD_RESP: begin
              tag_d   = cmd_i.tag;
              scan_d  = head_q;
              left_d  = occ_q;
              state_d = BK_SCAN;
            end
            CMD_STEP: begin
              if ((w_eff == '0) || (occ_q == '0) || !rdy_q[head_q]) begin
                out_valid_d       = 1'b1;
                out_d.result_kind = RES_NONE;
                out_d.retired_tag = '0;
                out_d.entry_count = CountW'(occ_q);
                out_d.last        = 1'b1;
              end else begin
                n_d     = '0;
                state_d = BK_RET;
              end
            end
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        // rdata_q holds the tag at scan_q; head tag is refetched on the last entry
        if (left_q == '0) begin
          state_d = BK_RESP;
        end else begin
          if (rdata_q == tag_q) begin
            rdy_d[scan_q] = 1'b1;
          end
          scan_d = nxt(scan_q);
          left_d = left_q - 1'b1;
          if (left_q != OccW'(1)) begin
            raddr = nxt(scan_q);
          end
        end
      end
      BK_RESP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.result_kind = RES_RESP;
          out_d.retired_tag = '0;
          out_d.entry_count = CountW'(occ_q);
          out_d.last        = 1'b1;
          state_d           = BK_IDLE;
        end
      end
      BK_RET: begin
        if (out_free) begin
          rdy_d[head_q] = 1'b0;
          head_d        = head_nx;
          occ_d         = occ_q - 1'b1;
          n_d           = n_inc;
          raddr         = head_nx;
          out_valid_d       = 1'b1;
          out_d.result_kind = RES_RETIRED;
          out_d.retired_tag = rdata_q;
          out_d.entry_count = CountW'(occ_d);
          out_d.last        = last_ret;
          if (last_ret) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      scan_q      <= '0;
      occ_q       <= '0;
      left_q      <= '0;
      rdy_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      scan_q      <= scan_d;
      occ_q       <= occ_d;
      left_q      <= left_d;
      rdy_q       <= rdy_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    out_q <= out_d;
  end

  // tag memory, write-first read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[tail_q] <= cmd_i.tag;
    end
    if (we && (tail_q == raddr)) begin
      rdata_q <= cmd_i.tag;
    end else begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign occ_o       = occ_q;

endmodule

// ===== sv/reorder_buffer_inorder_retire.sv =====
// Reorder buffer with in-order retirement: one input item is handled at a time
// by the back end. A cache response compares every held entry in turn through
// the single read port of the tag memory; a step reads the head tag while it
// is accepted and then retires one entry per cycle through that port while the
// output is not stalled, up to the retire width, the last entry or an entry not ready.
// A two-entry queue decouples input acceptance, and a result register holds a
// result until it is taken; the back end accepts no new item while a result
// waits untaken. No clearing pass is needed after reset.
// Top level; depends on rob_pkg, rob_front and rob_back.
module reorder_buffer_inorder_retire #(
  parameter int DEPTH      = 32,
  parameter int MAX_RETIRE = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rob_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rob_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rob_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rob_pkg::CfgDataW-1:0]      cfg_data_i
);
  import rob_pkg::*;

  localparam int OccW = $clog2(DEPTH + 1);

  cfg_t            cfg_q;
  cmd_t            cmd;
  logic            cmd_valid, cmd_pop;
  logic [OccW-1:0] occ;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity     <= CapReset;
      cfg_q.retire_width <= RwReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAPACITY:     cfg_q.capacity     <= cfg_data_i[CapW-1:0];
        CFG_RETIRE_WIDTH: cfg_q.retire_width <= cfg_data_i[RwW-1:0];
        default: ;
      endcase
    end
  end

  rob_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rob_back #(
    .DEPTH      (DEPTH),
    .MAX_RETIRE (MAX_RETIRE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .occ_o       (occ)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OccW'(DEPTH))
    else $error("occupancy above depth");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ == $past(occ)) || (occ == $past(occ) + 1'b1) || (occ == $past(occ) - 1'b1))
    else $error("occupancy moved by more than one entry");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind != RES_RETIRED)
      |-> out_item_o.last && (out_item_o.retired_tag == '0))
    else $error("non-retire result without last flag or with a tag");

endmodule
